FILE: rtl/deq_pkg.sv
// Shared command codes, status codes and controller interface types for the deque.
package deq_pkg;

  // Command codes carried by each input transaction
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK       = 3'd4;

  // Status codes reported with each result
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Front and back value reported while the deque is empty
  localparam logic signed [31:0] EMPTY_MARK = 32'shFFFF_FFFF;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic execute;
    logic capture_read;
    logic load_out;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic read_needed;
  } ctrl_stat_t;

endpackage

FILE: rtl/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register one read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/deq_datapath.sv
// Deque datapath: ring pointers, cached front and back values, ring RAM and result register.
module deq_datapath #(
  parameter int DEPTH = 16,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deq_pkg::ctrl_cmd_t    ctrl,
  output deq_pkg::ctrl_stat_t   stat,
  input  logic [2:0]            command,
  input  logic signed [31:0]    data_value,
  output logic signed [31:0]    popped_value,
  output logic [1:0]            status,
  output logic signed [31:0]    front_value,
  output logic signed [31:0]    back_value,
  output logic                  is_empty,
  output logic [CW-1:0]         occupancy
);

  localparam logic [IW:0]   DEPTH_W = (IW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // Reduce a sum below twice the depth into a ring index
  function automatic logic [IW-1:0] ring_wrap(input logic [IW:0] s);
    logic [IW:0] r;
    r = (s >= DEPTH_W) ? (s - DEPTH_W) : s;
    return r[IW-1:0];
  endfunction

  logic [2:0]           cmd_q;
  logic signed [31:0]   val_q;
  logic [IW-1:0]        head;
  logic [CW-1:0]        count;
  logic signed [31:0]   front_q;
  logic signed [31:0]   back_q;
  logic signed [31:0]   popped_q;
  logic [1:0]           status_q;

  logic                 is_push;
  logic                 is_pop;
  logic                 full;
  logic                 empty;
  logic [IW-1:0]        head_dec;
  logic [IW-1:0]        head_inc;
  logic [IW-1:0]        tail_slot;
  logic [IW-1:0]        refill_back;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 rd_en;
  logic [IW-1:0]        rd_addr;
  logic [31:0]          rd_data;

  // Decode the held command against the current occupancy
  always_comb begin
    is_push     = (cmd_q == deq_pkg::CMD_PUSH_FRONT) || (cmd_q == deq_pkg::CMD_PUSH_BACK);
    is_pop      = (cmd_q == deq_pkg::CMD_POP_FRONT) || (cmd_q == deq_pkg::CMD_POP_BACK);
    full        = (count == FULL_CNT);
    empty       = (count == '0);
    head_dec    = (head == '0) ? LAST_IDX : head - 1'b1;
    head_inc    = (head == LAST_IDX) ? '0 : head + 1'b1;
    tail_slot   = ring_wrap({1'b0, head} + (IW + 1)'(count));
    refill_back = ring_wrap({1'b0, head} + (IW + 1)'(count) - (IW + 1)'(2));
  end

  // A pop that leaves two or more entries must fetch the new end from the ring
  assign stat.read_needed = is_pop && (count > CW'(2));

  // Ring RAM port control
  always_comb begin
    wr_en   = ctrl.execute && is_push && !full;
    wr_addr = (cmd_q == deq_pkg::CMD_PUSH_FRONT) ? head_dec : tail_slot;
    rd_en   = ctrl.execute && stat.read_needed;
    rd_addr = (cmd_q == deq_pkg::CMD_POP_FRONT) ? head_inc : refill_back;
  end

  deq_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (val_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Hold the accepted transaction
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cmd_q <= command;
      val_q <= data_value;
    end
  end

  // Update pointers and the cached ends of the deque
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      count   <= '0;
      front_q <= deq_pkg::EMPTY_MARK;
      back_q  <= deq_pkg::EMPTY_MARK;
    end else if (ctrl.execute) begin
      unique case (cmd_q)
        deq_pkg::CMD_PUSH_FRONT: begin
          if (!full) begin
            head    <= head_dec;
            count   <= count + 1'b1;
            front_q <= val_q;
            if (empty) begin
              back_q <= val_q;
            end
          end
        end
        deq_pkg::CMD_PUSH_BACK: begin
          if (!full) begin
            count  <= count + 1'b1;
            back_q <= val_q;
            if (empty) begin
              front_q <= val_q;
            end
          end
        end
        deq_pkg::CMD_POP_FRONT: begin
          if (!empty) begin
            head  <= head_inc;
            count <= count - 1'b1;
            if (count == CW'(1)) begin
              front_q <= deq_pkg::EMPTY_MARK;
              back_q  <= deq_pkg::EMPTY_MARK;
            end else if (count == CW'(2)) begin
              front_q <= back_q;
            end
          end
        end
        deq_pkg::CMD_POP_BACK: begin
          if (!empty) begin
            count <= count - 1'b1;
            if (count == CW'(1)) begin
              front_q <= deq_pkg::EMPTY_MARK;
              back_q  <= deq_pkg::EMPTY_MARK;
            end else if (count == CW'(2)) begin
              back_q <= front_q;
            end
          end
        end
        default: begin
        end
      endcase
    end else if (ctrl.capture_read) begin
      // Take the refilled end from the ring
      if (cmd_q == deq_pkg::CMD_POP_FRONT) begin
        front_q <= rd_data;
      end else begin
        back_q <= rd_data;
      end
    end
  end

  // Record popped value and status of the transaction
  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      popped_q <= '0;
      status_q <= deq_pkg::ST_DONE;
      if (is_push && full) begin
        status_q <= deq_pkg::ST_FULL;
      end else if (is_pop && empty) begin
        status_q <= deq_pkg::ST_EMPTY;
      end else if (cmd_q == deq_pkg::CMD_POP_FRONT) begin
        popped_q <= front_q;
      end else if (cmd_q == deq_pkg::CMD_POP_BACK) begin
        popped_q <= back_q;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      popped_value <= popped_q;
      status       <= status_q;
      front_value  <= front_q;
      back_value   <= back_q;
      is_empty     <= (count == '0);
      occupancy    <= count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("occupancy beyond depth");

  a_head_bound: assert property (@(posedge clk) disable iff (rst)
    head <= LAST_IDX)
    else $error("head index outside ring");

  a_empty_marks: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (front_q == deq_pkg::EMPTY_MARK) && (back_q == deq_pkg::EMPTY_MARK))
    else $error("empty deque without empty marks");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (ctrl.execute && is_push && !full) |=> (count == $past(count) + 1'b1))
    else $error("accepted push did not grow occupancy");

endmodule

FILE: rtl/deq_ctrl.sv
// Deque controller: sequences accept, execute, ring read and result hand-off.
module deq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output deq_pkg::ctrl_cmd_t  ctrl,
  input  deq_pkg::ctrl_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_PUT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Drive datapath commands from the current state
  always_comb begin
    ctrl.load_item    = (state == S_IDLE) && in_valid;
    ctrl.execute      = (state == S_EXEC);
    ctrl.capture_read = (state == S_READ);
    ctrl.load_out     = (state == S_PUT) && out_free;
  end

  // Advance the sequence and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          state <= stat.read_needed ? S_READ : S_PUT;
        end
        S_READ: begin
          state <= S_PUT;
        end
        S_PUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_read_after_exec: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ($past(state) == S_EXEC))
    else $error("ring read without execute");

  a_exec_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_EXEC))
    else $error("accepted transaction not executed");

  a_put_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> out_valid)
    else $error("result loaded without valid");

endmodule

FILE: rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue: controller and datapath joined.
// Double-ended queue of signed 32-bit values in a ring RAM of DEPTH entries. Each input
// transaction carries a command (push front, push back, pop front, pop back, peek; codes
// five to seven act as peek) and yields exactly one result with the popped value, status,
// the front and back values after the step (-1 when empty), an empty flag and the
// occupancy. The front and back values are cached in registers, so most commands pass from
// the execute state straight to the output register. A pop that leaves two or more entries
// reads the new end from the ring RAM's registered read port and passes through a read
// state before that. One transaction is worked on at a time; the next is accepted in the
// cycle in which the previous result sits in the output register, and a stalled output
// holds the unit until the result can be loaded. The ring RAM needs no clearing after
// reset: only entries written by pushes are ever read.
module double_ended_queue_unit #(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  input  logic signed [31:0]  data_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  popped_value,
  output logic [1:0]          status,
  output logic signed [31:0]  front_value,
  output logic signed [31:0]  back_value,
  output logic                is_empty,
  output logic [CW-1:0]       occupancy
);

  deq_pkg::ctrl_cmd_t  ctrl;
  deq_pkg::ctrl_stat_t stat;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .stat         (stat),
    .command      (command),
    .data_value   (data_value),
    .popped_value (popped_value),
    .status       (status),
    .front_value  (front_value),
    .back_value   (back_value),
    .is_empty     (is_empty),
    .occupancy    (occupancy)
  );

endmodule
